// ===== src/sct_pkg.sv =====
// shared types, constants and register codes for the command tokenizer
`timescale 1ns / 1ps

package sct_pkg;

  localparam int MAX_STORE   = 256;
  localparam int MAX_ARGS    = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_STORE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARG_SLOTS  = 2'd1;

  localparam logic [8:0] STORE_SIZE_RESET = 9'd256;
  localparam logic [4:0] ARG_SLOTS_RESET  = 5'd16;

  typedef enum logic [1:0] {
    CLS_END,
    CLS_SPACE,
    CLS_WORD,
    CLS_BAD
  } byte_cls_t;

  typedef struct packed {
    logic [7:0] data;
    byte_cls_t  cls;
  } cmd_word_t;

  typedef struct packed {
    logic      valid;
    cmd_word_t word;
  } cmd_link_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_offset;
    logic [7:0] write_byte;
    logic       token_begin;
    logic [3:0] token_number;
    logic       finished;
    logic       accepted;
    logic [4:0] arg_count;
  } res_t;

endpackage

// ===== src/sct_fifo.sv =====
// small first-in first-out queue of fixed-width words
`timescale 1ns / 1ps

module sct_fifo #(
  parameter int DEPTH = 2,
  parameter int W     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] slot_r [DEPTH];
  logic [AW:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]  rd_ptr_r, rd_ptr_nxt;
  logic         do_push, do_pop;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = do_push ? wr_ptr_r + {{AW{1'b0}}, 1'b1} : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? rd_ptr_r + {{AW{1'b0}}, 1'b1} : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r[AW-1:0]] <= wdata;
    end
  end

endmodule

// ===== src/sct_front.sv =====
// front end: takes command bytes, sorts them into classes and queues them
`timescale 1ns / 1ps

module sct_front
  import sct_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_command_byte,
  output logic       in_full,
  output cmd_link_t  link,
  input  logic       link_pop
);

  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7a;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5a;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SPACE = 8'h20;

  cmd_word_t in_word;
  cmd_word_t q_word;
  logic      q_empty;
  logic      allowed;

  always_comb begin
    allowed = ((in_command_byte >= CH_LO_A) && (in_command_byte <= CH_LO_Z)) ||
              ((in_command_byte >= CH_UP_A) && (in_command_byte <= CH_UP_Z)) ||
              ((in_command_byte >= CH_0) && (in_command_byte <= CH_9)) ||
              (in_command_byte == CH_UNDER) || (in_command_byte == CH_DASH) ||
              (in_command_byte == CH_DOT) || (in_command_byte == CH_SLASH) ||
              (in_command_byte == CH_PLUS) || (in_command_byte == CH_COMMA) ||
              (in_command_byte == CH_COLON) || (in_command_byte == CH_EQUAL) ||
              (in_command_byte == CH_AT);
    in_word.data = in_command_byte;
    if (in_command_byte == 8'h00) begin
      in_word.cls = CLS_END;
    end else if (in_command_byte == CH_SPACE) begin
      in_word.cls = CLS_SPACE;
    end else if (allowed) begin
      in_word.cls = CLS_WORD;
    end else begin
      in_word.cls = CLS_BAD;
    end
  end

  sct_fifo #(
    .DEPTH (DEPTH),
    .W     ($bits(cmd_word_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_word),
    .full  (in_full),
    .pop   (link_pop),
    .rdata (q_word),
    .empty (q_empty)
  );

  assign link.valid = !q_empty;
  assign link.word  = q_word;

endmodule

// ===== src/sct_back.sv =====
// back end: tokenizer state, configuration registers and result words
`timescale 1ns / 1ps

module sct_back
  import sct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  cmd_link_t             link,
  output logic                  link_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output res_t                  res
);

  logic [8:0] store_size_r;
  logic [4:0] arg_slots_r;

  logic       inside_r, inside_nxt;
  logic       after_r, after_nxt;
  logic       rej_r, rej_nxt;
  logic [8:0] off_r, off_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  logic [8:0] cap;
  logic [4:0] slots;
  logic [3:0] tok_prev;
  logic       go;
  logic       room;

  assign go       = link.valid && !res_full;
  assign link_pop = go;
  assign res_push = go;

  assign cap      = (store_size_r < 9'(MAX_STORE)) ? store_size_r : 9'(MAX_STORE);
  assign slots    = (arg_slots_r < 5'(MAX_ARGS)) ? arg_slots_r : 5'(MAX_ARGS);
  assign tok_prev = (cnt_r == 5'd0) ? 4'd0 : 4'(cnt_r - 5'd1);
  assign room     = (off_r < cap);

  always_comb begin
    inside_nxt = inside_r;
    after_nxt  = after_r;
    rej_nxt    = rej_r;
    off_nxt    = off_r;
    cnt_nxt    = cnt_r;
    res        = '0;
    if (link.word.cls == CLS_END) begin
      res.finished = 1'b1;
      if (!rej_r && !after_r && inside_r && room) begin
        res.write_valid  = 1'b1;
        res.write_offset = off_r[7:0];
        res.token_number = tok_prev;
        if (cnt_r < slots) begin
          res.accepted  = 1'b1;
          res.arg_count = cnt_r;
        end
      end
      inside_nxt = 1'b0;
      after_nxt  = 1'b0;
      rej_nxt    = 1'b0;
      off_nxt    = '0;
      cnt_nxt    = '0;
    end else if (!rej_r && link.valid) begin
      unique case (link.word.cls)
        CLS_SPACE: begin
          if (after_r || !inside_r || !room) begin
            rej_nxt = 1'b1;
          end else begin
            res.write_valid  = 1'b1;
            res.write_offset = off_r[7:0];
            res.token_number = tok_prev;
            off_nxt    = off_r + 9'd1;
            inside_nxt = 1'b0;
            after_nxt  = 1'b1;
          end
        end
        CLS_WORD: begin
          if ((!inside_r && (cnt_r >= slots)) || !room) begin
            rej_nxt = 1'b1;
          end else begin
            res.write_valid  = 1'b1;
            res.write_offset = off_r[7:0];
            res.write_byte   = link.word.data;
            res.token_begin  = !inside_r;
            // a new token takes the index equal to the count before it
            res.token_number = inside_r ? tok_prev : cnt_r[3:0];
            if (!inside_r) begin
              cnt_nxt    = cnt_r + 5'd1;
              inside_nxt = 1'b1;
            end
            off_nxt   = off_r + 9'd1;
            after_nxt = 1'b0;
          end
        end
        CLS_BAD: begin
          rej_nxt = 1'b1;
        end
        CLS_END: begin
          rej_nxt = rej_r;
        end
        default: begin
          rej_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      after_r  <= 1'b0;
      rej_r    <= 1'b0;
      off_r    <= '0;
      cnt_r    <= '0;
    end else if (go) begin
      inside_r <= inside_nxt;
      after_r  <= after_nxt;
      rej_r    <= rej_nxt;
      off_r    <= off_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_size_r <= STORE_SIZE_RESET;
      arg_slots_r  <= ARG_SLOTS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_STORE_SIZE) begin
        store_size_r <= cfg_wdata;
      end else if (cfg_index == CFG_ARG_SLOTS) begin
        arg_slots_r <= cfg_wdata[4:0];
      end
    end
  end

  a_rej_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (go && rej_r && (link.word.cls != CLS_END)) |-> !res.write_valid)
    else $error("write reported after rejection");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (link.word.cls == CLS_END)) |=> (off_r == 9'd0 && cnt_r == 5'd0 && !rej_r))
    else $error("state not cleared after end of command");

  a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= 9'(MAX_STORE))
    else $error("store offset past capacity");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(MAX_ARGS))
    else $error("token count past slot limit");

  a_accept_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res.accepted) |-> (res.finished && res.write_valid))
    else $error("verdict without closing write");

endmodule

// ===== src/safe_command_tokenizer.sv =====
// top level of the command tokenizer: front end, back end and result queue
`timescale 1ns / 1ps

// Takes a command line one byte a cycle on in_push/in_full while in_full is low and gives
// exactly one result word per byte on out_empty/out_pop, in order. Sustained rate is one byte
// per clock when neither queue stalls; a byte is first registered in the byte queue, then the
// back end works on the head of that queue and writes its result into the result queue, unless
// the result queue is full. Both queues hold QUEUE_DEPTH words by default, so either side
// may stall without stopping the other until its queue fills. cfg_ready is always
// high; store_size and arg_slots are to be written only while no command byte is
// in flight. After reset both registers hold their maximum values.
module safe_command_tokenizer
  import sct_pkg::*;
#(
  parameter int CMD_DEPTH = QUEUE_DEPTH,
  parameter int RES_DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [7:0]            in_command_byte,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_write_valid,
  output logic [7:0]            out_write_offset,
  output logic [7:0]            out_write_byte,
  output logic                  out_token_begin,
  output logic [3:0]            out_token_number,
  output logic                  out_finished,
  output logic                  out_accepted,
  output logic [4:0]            out_arg_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_link_t link;
  logic      link_pop;
  logic      res_full;
  logic      res_push;
  res_t      res;
  res_t      head;

  assign cfg_ready = 1'b1;

  sct_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_command_byte (in_command_byte),
    .in_full         (in_full),
    .link            (link),
    .link_pop        (link_pop)
  );

  sct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .link      (link),
    .link_pop  (link_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  sct_fifo #(
    .DEPTH (RES_DEPTH),
    .W     ($bits(res_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (head),
    .empty (out_empty)
  );

  assign out_write_valid  = head.write_valid;
  assign out_write_offset = head.write_offset;
  assign out_write_byte   = head.write_byte;
  assign out_token_begin  = head.token_begin;
  assign out_token_number = head.token_number;
  assign out_finished     = head.finished;
  assign out_accepted     = head.accepted;
  assign out_arg_count    = head.arg_count;

endmodule

// ===== tb/sv/safe_command_tokenizer_checker.sv =====
// checker for the command tokenizer: predicts each result word and compares it
`timescale 1ns / 1ps

module safe_command_tokenizer_checker
  import sct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [7:0]            in_command_byte,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic                  out_write_valid,
  input  logic [7:0]            out_write_offset,
  input  logic [7:0]            out_write_byte,
  input  logic                  out_token_begin,
  input  logic [3:0]            out_token_number,
  input  logic                  out_finished,
  input  logic                  out_accepted,
  input  logic [4:0]            out_arg_count,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    words_owed,
  output int                    words_checked,
  output int                    commands_ok,
  output int                    commands_refused
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_END   = 8'h00;
  localparam int         MAX_PRINTED = 40;

  // shadow registers and parser state
  logic [8:0] store_limit;
  logic [4:0] slot_limit;
  logic       in_word;
  logic       after_sep;
  logic       refused;
  logic [8:0] fill;
  logic [4:0] tokens;

  res_t predicted_words[$];

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report($sformatf("word %0d: %s is %0h, predicted %0h", words_checked, name, got, want));
  endtask

  function automatic byte_cls_t classify(input logic [7:0] c);
    if (c == CH_END) return CLS_END;
    if (c == CH_SPACE) return CLS_SPACE;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
      return CLS_WORD;
    case (c)
      "_", "-", ".", "/", "+", ",", ":", "=", "@": return CLS_WORD;
      default: return CLS_BAD;
    endcase
  endfunction

  function automatic void clear_command();
    in_word   = 1'b0;
    after_sep = 1'b0;
    refused   = 1'b0;
    fill      = '0;
    tokens    = '0;
  endfunction

  // a separator or closing zero belongs to the token before it
  function automatic res_t store_word(input logic [8:0] off, input logic [7:0] b,
                                     input logic first);
    res_t r;
    r = '0;
    r.write_valid  = 1'b1;
    r.write_offset = off[7:0];
    r.write_byte   = b;
    r.token_begin  = first;
    r.token_number = (tokens != 0) ? 4'(tokens - 5'd1) : 4'd0;
    return r;
  endfunction

  function automatic res_t tokenize_byte(input logic [7:0] c);
    res_t r;
    int   cap;
    int   slots;
    logic first;
    r     = '0;
    first = 1'b0;
    cap   = (store_limit > MAX_STORE) ? MAX_STORE : int'(store_limit);
    slots = (slot_limit > MAX_ARGS) ? MAX_ARGS : int'(slot_limit);
    case (classify(c))
      CLS_END: begin
        if (!refused && !after_sep && in_word && fill < cap) begin
          // closing zero is written even when the token count then fails
          r = store_word(fill, CH_END, 1'b0);
          if (tokens < slots) begin
            r.accepted  = 1'b1;
            r.arg_count = tokens;
          end
        end
        r.finished = 1'b1;
        if (r.accepted) commands_ok++;
        else commands_refused++;
        clear_command();
      end
      CLS_SPACE: begin
        if (!refused) begin
          if (after_sep || !in_word || fill >= cap) begin
            refused = 1'b1;
          end else begin
            r         = store_word(fill, CH_END, 1'b0);
            fill      = fill + 9'd1;
            in_word   = 1'b0;
            after_sep = 1'b1;
          end
        end
      end
      CLS_WORD: begin
        if (!refused) begin
          if ((!in_word && tokens >= slots) || fill >= cap) begin
            refused = 1'b1;
          end else begin
            if (!in_word) begin
              first   = 1'b1;
              tokens  = tokens + 5'd1;
              in_word = 1'b1;
            end
            r         = store_word(fill, c, first);
            fill      = fill + 9'd1;
            after_sep = 1'b0;
          end
        end
      end
      default: begin
        refused = 1'b1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      store_limit = STORE_SIZE_RESET;
      slot_limit  = ARG_SLOTS_RESET;
      clear_command();
      predicted_words.delete();
    end else begin
      // retire first: a word popped now cannot come from a byte taken now
      if (out_pop && !out_empty) begin
        if (predicted_words.size() == 0) begin
          report($sformatf("result word %0d arrived with nothing predicted", words_checked));
        end else begin
          want = predicted_words.pop_front();
          check_field("write_valid", 8'(out_write_valid), 8'(want.write_valid));
          check_field("write_offset", out_write_offset, want.write_offset);
          check_field("write_byte", out_write_byte, want.write_byte);
          check_field("token_begin", 8'(out_token_begin), 8'(want.token_begin));
          check_field("token_number", 8'(out_token_number), 8'(want.token_number));
          check_field("finished", 8'(out_finished), 8'(want.finished));
          check_field("accepted", 8'(out_accepted), 8'(want.accepted));
          check_field("arg_count", 8'(out_arg_count), 8'(want.arg_count));
        end
        words_checked++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STORE_SIZE: store_limit = cfg_wdata[8:0];
          CFG_ARG_SLOTS:  slot_limit  = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) predicted_words.push_back(tokenize_byte(in_command_byte));
    end
    words_owed <= predicted_words.size();
  end

endmodule

// ===== tb/sv/safe_command_tokenizer_tb.sv =====
// testbench top: drives command bytes and register writes and gives the verdict
`timescale 1ns / 1ps

module safe_command_tokenizer_tb;
  import sct_pkg::*;

  localparam int                   WATCHDOG_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;  // unmapped, must be ignored
  localparam logic [7:0]           CH_SPACE       = 8'h20;
  localparam logic [7:0]           CH_END         = 8'h00;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_push         = 1'b0;
  logic [7:0]            in_command_byte = '0;
  logic                  out_pop         = 1'b0;
  logic                  cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_write_valid;
  logic [7:0]            out_write_offset;
  logic [7:0]            out_write_byte;
  logic                  out_token_begin;
  logic [3:0]            out_token_number;
  logic                  out_finished;
  logic                  out_accepted;
  logic [4:0]            out_arg_count;
  logic                  cfg_ready;

  int fail_count;
  int words_owed;
  int words_checked;
  int commands_ok;
  int commands_refused;

  int         bytes_sent    = 0;
  int         phase_bytes   = 0;
  int         settings_used = 0;
  int         quiet         = 0;
  int         store_eff     = 256;
  int         slot_eff      = 16;
  bit         calm          = 1'b0;
  logic [7:0] cmd_q[$];

  always #2 clk = ~clk;

  safe_command_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_command_byte  (in_command_byte),
    .in_full          (in_full),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_write_valid  (out_write_valid),
    .out_write_offset (out_write_offset),
    .out_write_byte   (out_write_byte),
    .out_token_begin  (out_token_begin),
    .out_token_number (out_token_number),
    .out_finished     (out_finished),
    .out_accepted     (out_accepted),
    .out_arg_count    (out_arg_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  safe_command_tokenizer_checker tok_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command_byte  (in_command_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_write_valid  (out_write_valid),
    .out_write_offset (out_write_offset),
    .out_write_byte   (out_write_byte),
    .out_token_begin  (out_token_begin),
    .out_token_number (out_token_number),
    .out_finished     (out_finished),
    .out_accepted     (out_accepted),
    .out_arg_count    (out_arg_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .words_owed       (words_owed),
    .words_checked    (words_checked),
    .commands_ok      (commands_ok),
    .commands_refused (commands_refused)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 70);
    if (r < 26) return 8'h61 + 8'(r);        // a..z
    if (r < 52) return 8'h41 + 8'(r - 26);   // A..Z
    if (r < 62) return 8'h30 + 8'(r - 52);   // 0..9
    case (r - 62)
      0: return "_";
      1: return "-";
      2: return ".";
      3: return "/";
      4: return "+";
      5: return ",";
      6: return ":";
      7: return "=";
      default: return "@";
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_command_byte <= b;
    do @(posedge clk); while (in_full);
    bytes_sent++;
    phase_bytes++;
  endtask

  task automatic send_queued();
    foreach (cmd_q[i]) send_byte(cmd_q[i]);
  endtask

  task automatic send_text(input string s);
    cmd_q.delete();
    for (int i = 0; i < s.len(); i++) cmd_q.push_back(s[i]);
    cmd_q.push_back(CH_END);
    send_queued();
  endtask

  // mostly well-formed commands sized to the current limits, some broken on purpose
  task automatic build_command();
    int ntok;
    int len;
    int len_hint;
    int kind;
    int pos;
    cmd_q.delete();
    len_hint = (store_eff < 1) ? 1 : ((store_eff < 24) ? store_eff : 24);
    ntok = $urandom_range(1, slot_eff + 1);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) cmd_q.push_back(CH_SPACE);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len_hint) : $urandom_range(1, 4);
      repeat (len) cmd_q.push_back(word_char());
    end
    kind = $urandom_range(0, 99);
    pos  = $urandom_range(0, cmd_q.size() - 1);
    if (kind < 8) begin
      cmd_q[pos] = 8'($urandom_range(1, 255));
    end else if (kind < 12) begin
      cmd_q.push_front(CH_SPACE);
    end else if (kind < 16) begin
      cmd_q.push_back(CH_SPACE);
    end else if (kind < 20) begin
      cmd_q.insert(pos, CH_SPACE);
      cmd_q.insert(pos, CH_SPACE);
    end else if (kind < 24) begin
      cmd_q.delete();
    end else if (kind < 28) begin
      cmd_q.delete();
      repeat ($urandom_range(1, 8)) cmd_q.push_back(8'($urandom_range(1, 255)));
    end
    cmd_q.push_back(CH_END);
  endtask

  task automatic random_commands(input int budget);
    phase_bytes = 0;
    while (phase_bytes < budget) begin
      build_command();
      send_queued();
    end
  endtask

  // stop pushing and let every predicted word drain
  task automatic finish_phase();
    in_push <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [8:0] store_val, input logic [8:0] slot_val);
    cfg_write(CFG_STORE_SIZE, store_val);
    cfg_write(CFG_ARG_SLOTS, slot_val);
    cfg_valid <= 1'b0;
    store_eff = (store_val > 256) ? 256 : int'(store_val);
    slot_eff  = (slot_val[4:0] > 16) ? 16 : int'(slot_val[4:0]);
    settings_used++;
  endtask

  initial begin : drain
    int n;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_pop <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("safe_command_tokenizer: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;
    @(posedge clk);

    // reset limits: edge characters, every separator rule, an unsafe byte
    send_text("a_-./+,:=@ Z09");
    send_text("");
    send_text(" a");
    send_text("a ");
    send_text("a  b");
    cmd_q.delete();
    cmd_q.push_back(8'h61);
    cmd_q.push_back(8'hff);
    cmd_q.push_back(8'h62);
    cmd_q.push_back(CH_END);
    send_queued();
    // one token that fills the store to its last offset
    cmd_q.delete();
    repeat (255) cmd_q.push_back(word_char());
    cmd_q.push_back(CH_END);
    send_queued();
    random_commands(100);
    finish_phase();

    // zero capacity and zero slots refuse everything
    set_config(9'd0, 9'd0);
    random_commands(30);
    finish_phase();

    set_config(9'd1, 9'd1);
    random_commands(40);
    finish_phase();

    // a store of two bytes leaves no room for the second token: command refused, no closing zero
    set_config(9'd2, 9'd2);
    send_text("a b");
    random_commands(60);
    finish_phase();

    // values above range are clipped to the built-in maxima
    cfg_write(CFG_SPARE, 9'($urandom));
    set_config(9'd511, {4'($urandom), 5'd31});
    random_commands(80);
    finish_phase();

    calm = 1'b1;
    set_config(9'd256, 9'd16);
    random_commands(100);
    finish_phase();

    repeat (4) begin
      calm = ($urandom_range(0, 3) == 0);
      set_config(9'($urandom_range(3, 40)), 9'($urandom_range(1, 6)));
      random_commands(40);
      finish_phase();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk);
    $display("sent %0d bytes in %0d commands (%0d accepted, %0d refused), %0d limit settings",
             bytes_sent, commands_ok + commands_refused, commands_ok, commands_refused,
             settings_used);
    $display("compared %0d result words, %0d field mismatches", words_checked, fail_count);
    if (fail_count == 0)
      $display("safe_command_tokenizer: match");
    else
      $display("safe_command_tokenizer: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sct_pkg.sv
src/sct_fifo.sv
src/sct_front.sv
src/sct_back.sv
src/safe_command_tokenizer.sv
tb/sv/safe_command_tokenizer_checker.sv
tb/sv/safe_command_tokenizer_tb.sv
